// ----- src/spc_pkg.sv -----
// Shared constants, types and helpers of the substring position classifier.
package spc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 5;

  // Result codes.
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EQUAL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSIDE = 3'd4;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_LOW    = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } spc_cell_ctl_t;

  // Picks pattern byte idx from the two configured pattern words.
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [DATA_W-1:0] low_word,
                                                     input logic [DATA_W-1:0] high_word,
                                                     input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] word;
    word = idx[IDX_W-1] ? high_word : low_word;
    return word[idx[IDX_W-2:0]*BYTE_W +: BYTE_W];
  endfunction

  // Clamps the configured length into 1..MAX_PATTERN.
  function automatic logic [LEN_W-1:0] active_length(input logic [LEN_W-1:0] len);
    if (len == '0) begin
      return LEN_W'(1);
    end else if (len > LEN_W'(MAX_PATTERN)) begin
      return LEN_W'(MAX_PATTERN);
    end
    return len;
  endfunction

endpackage

// ----- src/spc_cell.sv -----
// One window cell: holds a text byte, passes it on and compares its incoming byte.
module spc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spc_pkg::spc_cell_ctl_t        ctl,
  input  logic                          enable,
  input  logic [spc_pkg::BYTE_W-1:0]    byte_in,
  input  logic [spc_pkg::BYTE_W-1:0]    pat_byte,
  output logic [spc_pkg::BYTE_W-1:0]    byte_out,
  output logic                          match
);
  import spc_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // A cell beyond the pattern length never blocks a match.
  assign match    = !enable || (byte_in == pat_byte);
  assign byte_out = byte_r;

endmodule

// ----- src/spc_regs.sv -----
// Configuration register file behind the APB-style port.
module spc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spc_pkg::ADDR_W-1:0]    paddr,
  input  logic [spc_pkg::DATA_W-1:0]    pwdata,
  output logic [spc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [spc_pkg::LEN_W-1:0]     pattern_length,
  output logic [spc_pkg::DATA_W-1:0]    pattern_low_bytes,
  output logic [spc_pkg::DATA_W-1:0]    pattern_high_bytes
);
  import spc_pkg::*;

  logic [LEN_W-1:0]  length_r;
  logic [DATA_W-1:0] low_r;
  logic [DATA_W-1:0] high_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= LEN_W'(1);
      low_r    <= '0;
      high_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LENGTH: length_r <= pwdata[LEN_W-1:0];
        REG_LOW:    low_r    <= pwdata;
        REG_HIGH:   high_r   <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, length_r};
      REG_LOW:    prdata = low_r;
      REG_HIGH:   prdata = high_r;
      default:    prdata = '0;
    endcase
  end

  assign pattern_length     = length_r;
  assign pattern_low_bytes  = low_r;
  assign pattern_high_bytes = high_r;

endmodule

// ----- src/substring_position_classifier.sv -----
// Top level of the substring position classifier.
//
// The input channel carries one text byte per transfer, with in_is_last on
// the final byte of a string. The result channel carries one match_kind
// code per string, produced by the transfer that carries the last byte:
// none, equal, pattern at start, pattern at end, or inside.
// A row of sixteen cells holds the most recent bytes; every accepted byte
// shifts the row by one and all cells compare against the pattern at once,
// so one byte is taken in every cycle while in_stall is low. The result
// appears on out_valid in the cycle after the last byte's transfer.
// The user must set the pattern through the APB-style port only while no
// string is in flight; the block does not enforce this. pready is always high.
// Reset clears the window, the byte count, the match marks and the output
// valid flag, and sets the pattern length to one with an all-zero pattern.
// While a result waits and the receiver holds out_stall, in_stall is raised;
// otherwise the input side keeps flowing even with a result pending.
module substring_position_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spc_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spc_pkg::KIND_W-1:0]    out_match_kind,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spc_pkg::ADDR_W-1:0]    paddr,
  input  logic [spc_pkg::DATA_W-1:0]    pwdata,
  output logic [spc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import spc_pkg::*;

  logic [LEN_W-1:0]  cfg_length;
  logic [DATA_W-1:0] cfg_low;
  logic [DATA_W-1:0] cfg_high;
  logic [LEN_W-1:0]  plen;

  logic [BYTE_W-1:0] chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] cell_match;
  spc_cell_ctl_t     cell_ctl;

  logic              accept;
  logic [LEN_W-1:0]  seen_r, seen_nxt;
  logic              found_r, found_nxt;
  logic              at_start_r, at_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [LEN_W-1:0]  seen_inc;
  logic              hit;
  logic              new_first;
  logic              new_at_start;
  logic [KIND_W-1:0] kind_now;

  spc_regs u_regs (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .pattern_length     (cfg_length),
    .pattern_low_bytes  (cfg_low),
    .pattern_high_bytes (cfg_high)
  );

  assign plen     = active_length(cfg_length);
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign cell_ctl.shift = accept;
  assign cell_ctl.clear = accept && in_is_last;
  assign chain[0]       = in_text_byte;

  // Cell k compares the byte k places back, which lines up with pattern byte plen-1-k.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0] pat_pos;
    assign pat_pos = plen - LEN_W'(1) - LEN_W'(k);
    spc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .enable   (LEN_W'(k) < plen),
      .byte_in  (chain[k]),
      .pat_byte (pattern_byte(cfg_low, cfg_high, pat_pos[IDX_W-1:0])),
      .byte_out (chain[k+1]),
      .match    (cell_match[k])
    );
  end

  assign seen_inc     = (seen_r < LEN_W'(MAX_PATTERN)) ? seen_r + LEN_W'(1) : seen_r;
  assign hit          = (seen_inc >= plen) && (&cell_match);
  assign new_first    = hit && !found_r;
  assign new_at_start = new_first && (seen_r == plen - LEN_W'(1));

  always_comb begin
    if (new_first) begin
      kind_now = new_at_start ? KIND_EQUAL : KIND_END;
    end else if (found_r) begin
      kind_now = at_start_r ? KIND_START : KIND_INSIDE;
    end else begin
      kind_now = KIND_NONE;
    end
  end

  always_comb begin
    seen_nxt      = seen_r;
    found_nxt     = found_r;
    at_start_nxt  = at_start_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    if (accept) begin
      if (in_is_last) begin
        seen_nxt      = '0;
        found_nxt     = 1'b0;
        at_start_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
        kind_nxt      = kind_now;
      end else begin
        seen_nxt = seen_inc;
        if (new_first) begin
          found_nxt    = 1'b1;
          at_start_nxt = new_at_start;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      found_r     <= 1'b0;
      at_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      found_r     <= found_nxt;
      at_start_r  <= at_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_match_kind = kind_r;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result pending");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_last |=> out_valid_r)
    else $error("last byte did not produce a result");

  a_last_clears_string: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_last |=> (seen_r == '0) && !found_r && !at_start_r)
    else $error("string state not cleared after last byte");

  a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LEN_W'(MAX_PATTERN))
    else $error("byte count beyond window size");

  a_start_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    at_start_r |-> found_r)
    else $error("start mark set without a match");

endmodule

// ----- verif/substring_position_classifier_test.sv -----
// Self-checking testbench of the substring position classifier.
`timescale 1ns / 100ps

module substring_position_classifier_test;
  import spc_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 82;
  localparam int HOLD_PHASE = 7;
  localparam int PAUSE_PHASE = 4;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [1:0]        reg_idx;
    logic [63:0]       value;
    logic [7:0]        text;
    logic              last;
    logic              typed;
    logic [KIND_W-1:0] kind;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [BYTE_W-1:0] in_text_byte;
  logic in_is_last;
  logic out_valid;
  logic out_stall;
  logic [KIND_W-1:0] out_match_kind;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // Own copy of the block's configuration and string state.
  logic [4:0] length_reg = 5'd1;
  logic [127:0] pattern_bytes = '0;
  logic [7:0] window_bytes [MAX_PATTERN];
  int unsigned window_count = 0;
  bit seen_match = 0;
  bit match_at_byte0 = 0;

  logic [KIND_W-1:0] pending_kinds [$];
  row_t directed_rows [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase_idx = -1;
  logic rx_hold;
  logic [KIND_W-1:0] expected_kind;

  substring_position_classifier dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_match_kind (out_match_kind),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_length(input logic [4:0] len);
    if (len == 5'd0) begin
      return 1;
    end else if (len > MAX_PATTERN) begin
      return MAX_PATTERN;
    end
    return len;
  endfunction

  // Shifts one byte into the window and returns 1 with the code when the
  // byte closes a string.
  function automatic bit classify_byte(input logic [7:0] b, input bit last,
                                       output logic [KIND_W-1:0] kind);
    int unsigned n;
    int unsigned count_before;
    bit hit;
    bit first_hit;
    bit first_at_start;
    n = clamp_length(length_reg);
    count_before = window_count;
    for (int k = MAX_PATTERN - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
    window_bytes[0] = b;
    if (window_count < MAX_PATTERN) window_count++;
    hit = (window_count >= n);
    for (int k = 0; k < n; k++) begin
      if (window_bytes[k] != pattern_bytes[(n - 1 - k) * 8 +: 8]) hit = 0;
    end
    first_hit = hit && !seen_match;
    // The count is still below saturation whenever it can equal n - 1.
    first_at_start = first_hit && (count_before == n - 1);
    if (first_hit) begin
      seen_match = 1;
      match_at_byte0 = first_at_start;
    end
    kind = KIND_NONE;
    if (!last) return 0;
    if (first_hit) begin
      kind = first_at_start ? KIND_EQUAL : KIND_END;
    end else if (seen_match) begin
      kind = match_at_byte0 ? KIND_START : KIND_INSIDE;
    end
    foreach (window_bytes[i]) window_bytes[i] = '0;
    window_count = 0;
    seen_match = 0;
    match_at_byte0 = 0;
    return 1;
  endfunction

  function automatic row_t wr(input logic [1:0] idx, input logic [63:0] val);
    row_t r;
    r = '0;
    r.op = ROW_WRITE;
    r.reg_idx = idx;
    r.value = val;
    return r;
  endfunction

  function automatic row_t by(input logic [7:0] t, input bit last, input bit typed,
                              input logic [KIND_W-1:0] kind);
    row_t r;
    r = '0;
    r.op = ROW_BYTE;
    r.text = t;
    r.last = last;
    r.typed = typed;
    r.kind = kind;
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b, input bit last, input bit typed,
                          input logic [KIND_W-1:0] typed_kind);
    logic [KIND_W-1:0] kind;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    if (classify_byte(b, last, kind)) pending_kinds.push_back(typed ? typed_kind : kind);
  endtask

  // Lowers valid and lets every pending result drain before going on.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_kinds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LENGTH: length_reg = val[4:0];
      REG_LOW:    pattern_bytes[63:0] = val;
      REG_HIGH:   pattern_bytes[127:64] = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_text_byte(input int unsigned n);
    if ($urandom_range(9) < 7) return pattern_bytes[$urandom_range(0, n - 1) * 8 +: 8];
    return 8'($urandom);
  endfunction

  // Mostly strings that carry the pattern somewhere, plus noise and
  // strings with a damaged or cut-off copy of the pattern.
  task automatic run_phase(input int n_items, input bit pause_midway);
    logic [7:0] text [$];
    int sent;
    int len;
    int pos;
    int shape;
    int span;
    int j;
    int unsigned n;
    bit paused;
    sent = 0;
    paused = 0;
    n = clamp_length(length_reg);
    while (sent < n_items) begin
      text.delete();
      shape = $urandom_range(9);
      if (shape == 0) begin
        len = $urandom_range(1, 20);
      end else if (shape == 9) begin
        len = $urandom_range(1, n);
      end else begin
        len = n + $urandom_range(0, 8);
      end
      for (int i = 0; i < len; i++) begin
        text.push_back(shape == 0 ? 8'($urandom) : pick_text_byte(n));
      end
      if (shape != 0) begin
        if (len <= n) begin
          pos = 0;
        end else begin
          case ($urandom_range(2))
            0: pos = 0;
            1: pos = len - n;
            default: pos = $urandom_range(0, len - n);
          endcase
        end
        span = (len - pos < n) ? len - pos : n;
        for (int i = 0; i < span; i++) text[pos + i] = pattern_bytes[i * 8 +: 8];
        if (shape == 9) begin
          j = $urandom_range(0, span - 1);
          text[pos + j] = text[pos + j] ^ (8'd1 << $urandom_range(7));
        end
      end
      for (int i = 0; i < len; i++) put_byte(text[i], i == len - 1, 1'b0, KIND_NONE);
      sent += len;
      if (pause_midway && !paused && sent >= n_items / 2) begin
        wait_idle();
        paused = 1;
      end
    end
  endtask

  // Receiver: stalls at random and checks every result transfer.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_kinds.size() == 0) begin
          report_mismatch($sformatf("unexpected result, match_kind %0d", out_match_kind));
        end else begin
          expected_kind = pending_kinds.pop_front();
          if (out_match_kind !== expected_kind) begin
            report_mismatch($sformatf("match_kind %0d, expected %0d",
                                      out_match_kind, expected_kind));
          end
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off so that the block backs up into its input.
  initial begin
    rx_hold <= 1'b0;
    wait (phase_idx == HOLD_PHASE);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t row;
    logic [4:0] len_val;
    logic [63:0] low_val;
    logic [63:0] high_val;
    foreach (window_bytes[i]) window_bytes[i] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_text_byte <= '0;
    in_is_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    // Reset pattern is a single zero byte.
    directed_rows.push_back(by(8'h00, 1, 1, KIND_EQUAL));
    directed_rows.push_back(by(8'hFF, 1, 1, KIND_NONE));
    directed_rows.push_back(by(8'h41, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h00, 1, 1, KIND_END));
    directed_rows.push_back(by(8'h00, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h41, 1, 1, KIND_START));
    directed_rows.push_back(by(8'h41, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h00, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h42, 1, 1, KIND_INSIDE));
    // A length of zero acts as one.
    directed_rows.push_back(wr(REG_LENGTH, 64'd0));
    directed_rows.push_back(wr(REG_LOW, 64'h7F));
    directed_rows.push_back(by(8'h7F, 1, 1, KIND_EQUAL));
    directed_rows.push_back(wr(REG_LENGTH, 64'd2));
    directed_rows.push_back(wr(REG_LOW, 64'h3412));
    directed_rows.push_back(by(8'h12, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h34, 1, 1, KIND_EQUAL));
    directed_rows.push_back(by(8'h12, 1, 1, KIND_NONE));
    // Only the first of two matches decides the code.
    directed_rows.push_back(by(8'h12, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h34, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h12, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h34, 1, 1, KIND_START));
    // A write to an unused address must leave the pattern alone.
    directed_rows.push_back(wr(REG_UNUSED, 64'h1));
    directed_rows.push_back(by(8'h12, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'h34, 1, 0, KIND_NONE));
    directed_rows.push_back(wr(REG_LENGTH, 64'd31));
    directed_rows.push_back(wr(REG_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(by(8'h00, 0, 0, KIND_NONE));
    directed_rows.push_back(by(8'hFF, 1, 1, KIND_NONE));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct = 53;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.op == ROW_WRITE) begin
        wait_idle();
        write_reg(row.reg_idx, row.value);
      end else begin
        put_byte(row.text, row.last, row.typed, row.kind);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      phase_idx = p;
      if (p < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 53;
      end else if (p < 6) begin
        send_idle_pct = 53;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: len_val = 5'd16;
        1: len_val = 5'd1;
        2: len_val = 5'd31;
        3: len_val = 5'd0;
        4: len_val = 5'd16;
        5: len_val = 5'($urandom_range(17, 30));
        default: len_val = 5'($urandom_range(1, 16));
      endcase
      if (p == 0) begin
        low_val = '1;
        high_val = '1;
      end else if (p == 1) begin
        low_val = '0;
        high_val = '0;
      end else begin
        low_val = {$urandom, $urandom};
        high_val = {$urandom, $urandom};
      end
      write_reg(REG_LENGTH, 64'(len_val));
      write_reg(REG_LOW, low_val);
      write_reg(REG_HIGH, high_val);
      run_phase(PHASE_ITEMS, p == PAUSE_PHASE);
    end

    in_valid <= 1'b0;
    while (pending_kinds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/spc_pkg.sv
src/spc_cell.sv
src/spc_regs.sv
src/substring_position_classifier.sv
verif/substring_position_classifier_test.sv
